/* rtl/vfc_pkg.sv */
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the voxel face culling mesher
// Item and result words, configuration indexes, controller command and
// status groups, and the state, read phase and neighbor direction encodings.
// ----------------------------------------------------------------------------
package vfc_pkg;

  // Default grid limits.
  localparam int MAX_X_DEF = 16;
  localparam int MAX_Y_DEF = 64;
  localparam int MAX_Z_DEF = 16;

  // Width used to compare coordinates with sizes (covers MAX_Y up to 256).
  localparam int SIZE_W = 9;

  // Running face counter and the vertex number derived from it.
  localparam int CNT_W = 17;
  localparam int FV_W  = CNT_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [4:0] SIZE_X_RST = 5'd16;
  localparam logic [6:0] SIZE_Y_RST = 7'd64;
  localparam logic [4:0] SIZE_Z_RST = 5'd16;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MESH  = 1'b1;

  // Block types.
  localparam logic [1:0] TYPE_AIR = 2'd0;

  typedef struct packed {
    logic       kind;
    logic [3:0] voxel_x;
    logic [5:0] voxel_y;
    logic [3:0] voxel_z;
    logic [1:0] type_in;
  } vfc_in_t;

  typedef struct packed {
    logic [5:0]      face_mask;
    logic [1:0]      type_out;
    logic [2:0]      face_count;
    logic [FV_W-1:0] first_vertex;
    logic            range_error;
  } vfc_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_DONE
  } vfc_state_t;

  // Read round: which pair of voxels the two store ports fetch.
  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2,
    PH_3
  } vfc_phase_t;

  // Voxel picked relative to the current item.
  typedef enum logic [2:0] {
    DIR_C,
    DIR_XP,
    DIR_XN,
    DIR_YP,
    DIR_YN,
    DIR_ZP,
    DIR_ZN
  } vfc_dir_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       wr_en;
    logic       rd_en;
    vfc_phase_t phase;
    logic       out_load;
  } vfc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic out_free;
  } vfc_status_t;

endpackage

/* rtl/voxel_face_culling_mesher.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher: voxel grid with exposed face detection
// Stores block types of a voxel grid and, for a named voxel, reports its
// exposed faces, face count and first vertex number.
//
//   channel  signals                                   word / direction
//   in       in_valid, in_stall, in_data               vfc_in_t, into block
//   out      out_valid, out_stall, out_data            vfc_out_t, out of block
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data size registers, into block
//
// A write word goes from its accept step straight to the result step, where
// it is loaded into the output register; a mesh word first passes the read
// steps RD1, RD2 and RD3, for four rounds of paired reads on the
// two-read-port voxel store (the first in the accept step), the last of which
// feeds the result as it is formed. The next word is accepted in the cycle
// after the result is loaded. After reset the store is cleared one entry a
// cycle, all MAX_X*MAX_Y*MAX_Z entries (16384 at default size), with in_stall
// high; configuration writes are taken throughout. A stalled output holds the
// block in its result step until the waiting word is taken.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher #(
  parameter int MAX_X = vfc_pkg::MAX_X_DEF,
  parameter int MAX_Y = vfc_pkg::MAX_Y_DEF,
  parameter int MAX_Z = vfc_pkg::MAX_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vfc_pkg::vfc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vfc_pkg::vfc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vfc_pkg::*;

  vfc_cmd_t    cmd;
  vfc_status_t status;

  // Size registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  vfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vfc_datapath #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* rtl/vfc_ctrl.sv */
// ----------------------------------------------------------------------------
// vfc_ctrl: sequencer of the voxel face culling mesher
// Runs the clearing pass after reset, accepts items, steps the paired store
// reads of a mesh item and hands the result to the output register.
// ----------------------------------------------------------------------------
module vfc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  vfc_pkg::vfc_status_t   status,
  output vfc_pkg::vfc_cmd_t      cmd
);
  import vfc_pkg::*;

  vfc_state_t state;
  vfc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (status.kind == KIND_WRITE) ? ST_DONE : ST_RD1;
        end
      end
      ST_RD1: state_next = ST_RD2;
      ST_RD2: state_next = ST_RD3;
      ST_RD3: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.phase    = PH_0;
    in_stall     = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        cmd.load  = in_valid;
        cmd.wr_en = in_valid && (status.kind == KIND_WRITE);
        cmd.rd_en = in_valid;
        cmd.phase = PH_0;
      end
      ST_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.phase = PH_1;
      end
      ST_RD2: begin
        cmd.rd_en = 1'b1;
        cmd.phase = PH_2;
      end
      ST_RD3: begin
        cmd.rd_en = 1'b1;
        cmd.phase = PH_3;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  a_no_read_outside_item: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (state != ST_CLEAR) && (state != ST_DONE))
    else $error("store read issued outside an item");

  a_write_goes_to_done: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |=> state == ST_DONE)
    else $error("write item did not go to result step");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !status.out_free |=> state == ST_DONE)
    else $error("result step left while output register was full");

endmodule

/* rtl/vfc_datapath.sv */
// ----------------------------------------------------------------------------
// vfc_datapath: voxel store, neighbor reads and result forming
// Holds the size registers, the two-read-port voxel store with its clearing
// counter, the captured neighbor states, the face counter and the output
// register.
// ----------------------------------------------------------------------------
module vfc_datapath #(
  parameter int MAX_X = vfc_pkg::MAX_X_DEF,
  parameter int MAX_Y = vfc_pkg::MAX_Y_DEF,
  parameter int MAX_Z = vfc_pkg::MAX_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vfc_pkg::vfc_in_t                  in_data,
  input  logic                              cfg_valid,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  vfc_pkg::vfc_cmd_t                 cmd,
  output vfc_pkg::vfc_status_t              status,
  output logic                              out_valid,
  output vfc_pkg::vfc_out_t                 out_data,
  input  logic                              out_stall
);
  import vfc_pkg::*;

  localparam int DEPTH    = MAX_X * MAX_Y * MAX_Z;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STRIDE_X = MAX_Y * MAX_Z;
  localparam int STRIDE_Y = MAX_Z;

  // Configuration registers.
  logic [4:0] size_x;
  logic [6:0] size_y;
  logic [4:0] size_z;
  logic [SIZE_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_X_RST;
      size_y <= SIZE_Y_RST;
      size_z <= SIZE_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data[4:0];
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // A size above the grid limit acts as the limit.
  always_comb begin
    sx = (SIZE_W'(size_x) > SIZE_W'(MAX_X)) ? SIZE_W'(MAX_X) : SIZE_W'(size_x);
    sy = (SIZE_W'(size_y) > SIZE_W'(MAX_Y)) ? SIZE_W'(MAX_Y) : SIZE_W'(size_y);
    sz = (SIZE_W'(size_z) > SIZE_W'(MAX_Z)) ? SIZE_W'(MAX_Z) : SIZE_W'(size_z);
  end

  // Address of the voxel at or next to (x, y, z), with a flag that it lies inside the
  // configured size. A step below zero wraps to a large value and so fails
  // the bound check. Voxels outside map to address zero.
  function automatic logic [AW:0] nb_addr(
    input vfc_dir_t          d,
    input logic [SIZE_W-1:0] x,
    input logic [SIZE_W-1:0] y,
    input logic [SIZE_W-1:0] z,
    input logic [SIZE_W-1:0] lx,
    input logic [SIZE_W-1:0] ly,
    input logic [SIZE_W-1:0] lz
  );
    logic [SIZE_W-1:0] nx, ny, nz;
    logic              ok;
    int                lin;
    nx = x;
    ny = y;
    nz = z;
    unique case (d)
      DIR_C:  ;
      DIR_XP: nx = x + SIZE_W'(1);
      DIR_XN: nx = x - SIZE_W'(1);
      DIR_YP: ny = y + SIZE_W'(1);
      DIR_YN: ny = y - SIZE_W'(1);
      DIR_ZP: nz = z + SIZE_W'(1);
      DIR_ZN: nz = z - SIZE_W'(1);
      default: ;
    endcase
    ok  = (nx < lx) && (ny < ly) && (nz < lz);
    lin = int'(nx) * STRIDE_X + int'(ny) * STRIDE_Y + int'(nz);
    return {ok, ok ? AW'(lin) : AW'(0)};
  endfunction

  // Item latch.
  logic       item_kind;
  logic [3:0] item_x;
  logic [5:0] item_y;
  logic [3:0] item_z;
  logic [1:0] item_type;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= in_data.kind;
      item_x    <= in_data.voxel_x;
      item_y    <= in_data.voxel_y;
      item_z    <= in_data.voxel_z;
      item_type <= in_data.type_in;
    end
  end

  // The first read round runs in the accept cycle, straight from the input.
  logic [SIZE_W-1:0] cur_x, cur_y, cur_z;
  vfc_dir_t          dir_a, dir_b;
  logic [AW:0]       nb_a, nb_b;

  always_comb begin
    if (cmd.phase == PH_0) begin
      cur_x = SIZE_W'(in_data.voxel_x);
      cur_y = SIZE_W'(in_data.voxel_y);
      cur_z = SIZE_W'(in_data.voxel_z);
    end else begin
      cur_x = SIZE_W'(item_x);
      cur_y = SIZE_W'(item_y);
      cur_z = SIZE_W'(item_z);
    end
    unique case (cmd.phase)
      PH_0: begin dir_a = DIR_C;  dir_b = DIR_XP; end
      PH_1: begin dir_a = DIR_XN; dir_b = DIR_YP; end
      PH_2: begin dir_a = DIR_YN; dir_b = DIR_ZP; end
      PH_3: begin dir_a = DIR_ZN; dir_b = DIR_ZN; end
      default: begin dir_a = DIR_C; dir_b = DIR_C; end
    endcase
    nb_a = nb_addr(dir_a, cur_x, cur_y, cur_z, sx, sy, sz);
    nb_b = nb_addr(dir_b, cur_x, cur_y, cur_z, sx, sy, sz);
  end

  // Clearing pass counter.
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Voxel store: one write port, two registered read ports.
  logic [1:0]    store [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [1:0]    rdata_a, rdata_b;
  logic          ok_a, ok_b;

  always_comb begin
    mem_we    = cmd.clr_en || (cmd.wr_en && nb_a[AW]);
    mem_waddr = cmd.clr_en ? clr_addr : nb_a[AW-1:0];
    mem_wdata = cmd.clr_en ? TYPE_AIR : in_data.type_in;
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) begin
      rdata_a <= store[nb_a[AW-1:0]];
      rdata_b <= store[nb_b[AW-1:0]];
      ok_a    <= nb_a[AW];
      ok_b    <= nb_b[AW];
    end
  end

  // Each round after the first captures the data of the round before it.
  logic [1:0] center_type;
  logic [4:0] open_mask;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      unique case (cmd.phase)
        PH_0: ;
        PH_1: begin
          center_type  <= rdata_a;
          open_mask[0] <= !ok_b || (rdata_b == TYPE_AIR);
        end
        PH_2: begin
          open_mask[1] <= !ok_a || (rdata_a == TYPE_AIR);
          open_mask[2] <= !ok_b || (rdata_b == TYPE_AIR);
        end
        PH_3: begin
          open_mask[3] <= !ok_a || (rdata_a == TYPE_AIR);
          open_mask[4] <= !ok_b || (rdata_b == TYPE_AIR);
        end
        default: ;
      endcase
    end
  end

  // Result forming.
  logic [CNT_W-1:0] face_counter;
  logic [CNT_W-1:0] face_counter_next;
  logic             item_bad;
  logic             open_back;
  vfc_out_t         result;

  always_comb begin
    item_bad  = !((SIZE_W'(item_x) < sx) && (SIZE_W'(item_y) < sy) &&
                  (SIZE_W'(item_z) < sz));
    open_back = !ok_a || (rdata_a == TYPE_AIR);
    result             = '0;
    result.range_error = item_bad;
    face_counter_next  = face_counter;
    if (item_kind == KIND_WRITE) begin
      result.type_out   = item_bad ? TYPE_AIR : item_type;
      face_counter_next = '0;
    end else if (!item_bad) begin
      result.type_out     = center_type;
      result.first_vertex = {face_counter, 2'b00};
      if (center_type != TYPE_AIR) begin
        result.face_mask  = {open_back, open_mask};
        result.face_count = 3'($countones({open_back, open_mask}));
        face_counter_next = face_counter + CNT_W'(result.face_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_counter <= '0;
      out_valid    <= 1'b0;
    end else if (cmd.out_load) begin
      face_counter <= face_counter_next;
      out_valid    <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= result;
  end

  always_comb begin
    status.clr_last = (clr_addr == AW'(DEPTH - 1));
    status.kind     = in_data.kind;
    status.out_free = !out_valid || !out_stall;
  end

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result word appeared without a load");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.face_count == 3'($countones(out_data.face_mask)))
    else $error("face count disagrees with face mask");

  a_error_word_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_error |->
      (out_data.face_mask == '0) && (out_data.first_vertex == '0) &&
      (out_data.type_out == TYPE_AIR))
    else $error("out of range result carries data");

endmodule
